FILE: hw/rtl/hll_pkg.sv
// ----------------------------------------------------------------------------
// HyperLogLog sketch update - shared package
// Operation and result codes, hash constants and field widths used by the
// sketch update datapath and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package hll_pkg;

    // Field widths
    localparam int FUNC_W  = 3;
    localparam int KIND_W  = 2;
    localparam int KEY_W   = 8;
    localparam int HASH_W  = 64;
    localparam int INDEX_W = 14;
    localparam int VALUE_W = 6;
    localparam int CFG_W   = 4;
    // Wide enough for any effective precision, including the parameter range
    localparam int PREC_W  = 5;

    typedef logic [HASH_W-1:0]  hash_t;
    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [FUNC_W-1:0]  func_t;
    typedef logic [KIND_W-1:0]  kind_t;
    typedef logic [PREC_W-1:0]  prec_t;

    // Operation codes
    localparam func_t FUNC_KEY   = 3'd0;
    localparam func_t FUNC_HASH  = 3'd1;
    localparam func_t FUNC_MERGE = 3'd2;
    localparam func_t FUNC_READ  = 3'd3;
    localparam func_t FUNC_CLEAR = 3'd4;

    // Result kinds
    localparam kind_t KIND_UPDATE = 2'd0;
    localparam kind_t KIND_READ   = 2'd1;
    localparam kind_t KIND_CLEAR  = 2'd2;

    // Precision handling
    localparam prec_t                MIN_PREC   = 5'd4;
    localparam logic [CFG_W-1:0]     PREC_RESET = 4'd14;

    // Register value ceiling
    localparam value_t RHO_LIMIT = 6'd61;

    // FNV-1a 64: prime = 2^40 + 0x1b3
    localparam hash_t FNV_BASIS       = 64'hcbf29ce484222325;
    localparam hash_t FNV_PRIME_LO    = 64'h00000000000001b3;
    localparam int    FNV_PRIME_SHIFT = 40;

    // Finalizer constants
    localparam hash_t MIX_K1    = 64'hff51afd7ed558ccd;
    localparam hash_t MIX_K2    = 64'hc4ceb9fe1a85ec53;
    localparam int    MIX_SHIFT = 33;

endpackage

`default_nettype wire

FILE: hw/rtl/hyperloglog_sketch_update.sv
// Steps: a key byte that does not close the key runs only the FNV step; merge or read
// runs the memory read and write-back; a direct hash the rank pipeline and memory RMW;
// a closing key byte the FNV step, finalizer on one 32x32 multiplier, rank pipeline, RMW.
// Throughput: one item at a time; input is taken only while the sequencer is idle.
// Clear all zeroes every RAM entry, one RAM entry per cycle, then reports a clear result.
// Reset: synchronous, active low; a clearing pass over the RAM follows, inputs held off.
// ----------------------------------------------------------------------------
// HyperLogLog sketch update - top level
// FNV-1a key hashing, finalizer, rank computation and max-merge into a
// register RAM, plus entry merge, entry read and clear-all operations.
// ----------------------------------------------------------------------------
`default_nettype none

module hyperloglog_sketch_update #(
    parameter int MAX_PREC = 14
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Configuration write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [hll_pkg::CFG_W-1:0]     cfg_data,
    // Input channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire hll_pkg::func_t                s_func,
    input  wire logic [hll_pkg::KEY_W-1:0]     s_key_byte,
    input  wire logic                          s_last_byte,
    input  wire hll_pkg::hash_t                s_hash_in,
    input  wire logic [hll_pkg::INDEX_W-1:0]   s_entry_index,
    input  wire hll_pkg::value_t               s_entry_value,
    // Result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output hll_pkg::kind_t                     m_out_kind,
    output logic [hll_pkg::INDEX_W-1:0]        m_out_index,
    output hll_pkg::value_t                    m_out_value
);

    localparam int IDX_W = MAX_PREC;
    localparam int PW    = hll_pkg::PREC_W;

    // Sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_FNV   = 3'd2;
    localparam logic [2:0] S_MIX   = 3'd3;
    localparam logic [2:0] S_RHO   = 3'd4;
    localparam logic [2:0] S_RD    = 3'd5;
    localparam logic [2:0] S_WB    = 3'd6;

    logic [2:0]                     state_reg, state_next;
    logic [hll_pkg::CFG_W-1:0]      precision_reg, precision_next;
    hll_pkg::hash_t                 run_hash_reg, run_hash_next;
    hll_pkg::func_t                 func_reg, func_next;
    logic [hll_pkg::KEY_W-1:0]      byte_reg, byte_next;
    logic                           last_reg, last_next;
    logic [IDX_W-1:0]               idx_reg, idx_next;
    hll_pkg::value_t                val_reg, val_next;
    logic [IDX_W-1:0]               clr_addr_reg, clr_addr_next;
    logic                           clr_resp_reg, clr_resp_next;
    logic                           m_valid_reg, m_valid_next;
    hll_pkg::kind_t                 kind_reg, kind_next;
    logic [hll_pkg::INDEX_W-1:0]    index_reg, index_next;
    hll_pkg::value_t                value_reg, value_next;

    hll_pkg::prec_t                 eff_prec;
    logic [IDX_W-1:0]               prec_mask;
    logic [31:0]                    ent_ext;
    logic [31:0]                    idx_ext;
    logic [IDX_W-1:0]               ent_idx;
    hll_pkg::value_t                ent_val;
    hll_pkg::hash_t                 fnv_x;
    hll_pkg::hash_t                 fnv_next;
    logic                           accept;
    logic                           out_free;
    logic                           out_load;
    hll_pkg::value_t                merged;

    logic                           fmix_start;
    logic                           fmix_done;
    hll_pkg::hash_t                 fmix_hash;
    logic                           rho_start;
    hll_pkg::hash_t                 rho_hash;
    logic                           rho_done;
    logic [IDX_W-1:0]               rho_idx;
    hll_pkg::value_t                rho_val;

    logic                           mem_we;
    logic [IDX_W-1:0]               mem_waddr;
    hll_pkg::value_t                mem_wdata;
    logic                           mem_re;
    hll_pkg::value_t                mem_rdata;

    // Clamp precision and build the index mask
    always_comb begin
        if (PW'(precision_reg) < hll_pkg::MIN_PREC) begin
            eff_prec = hll_pkg::MIN_PREC;
        end else if (PW'(precision_reg) > PW'(MAX_PREC)) begin
            eff_prec = PW'(MAX_PREC);
        end else begin
            eff_prec = PW'(precision_reg);
        end
        for (int i = 0; i < IDX_W; i++) begin
            prec_mask[i] = PW'(i) < eff_prec;
        end
    end

    // Input field conditioning
    assign ent_ext = 32'(s_entry_index);
    assign ent_idx = ent_ext[IDX_W-1:0] & prec_mask;
    assign ent_val = (s_entry_value > hll_pkg::RHO_LIMIT) ? hll_pkg::RHO_LIMIT
                                                          : s_entry_value;

    // One FNV-1a step: xor the byte, multiply by 2^40 + 0x1b3
    assign fnv_x    = run_hash_reg ^ hll_pkg::HASH_W'(byte_reg);
    assign fnv_next = (fnv_x << hll_pkg::FNV_PRIME_SHIFT) + fnv_x * hll_pkg::FNV_PRIME_LO;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == S_WB) && out_free;
    assign merged   = (val_reg > mem_rdata) ? val_reg : mem_rdata;
    assign idx_ext  = 32'(idx_reg);

    // Hash unit handoffs
    assign fmix_start = (state_reg == S_FNV) && last_reg;
    assign rho_start  = (accept && (s_func == hll_pkg::FUNC_HASH))
                     || ((state_reg == S_MIX) && fmix_done);
    assign rho_hash   = (state_reg == S_MIX) ? fmix_hash : s_hash_in;

    // RAM port control: clear sweep or read-modify-write
    always_comb begin
        mem_re    = (state_reg == S_RD);
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = merged;
        if (state_reg == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end else if (out_load && (func_reg != hll_pkg::FUNC_READ)
                     && (func_reg != hll_pkg::FUNC_CLEAR)) begin
            mem_we = val_reg > mem_rdata;
        end
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        precision_next = cfg_valid ? cfg_data : precision_reg;
        run_hash_next  = run_hash_reg;
        func_next      = func_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        clr_addr_next  = clr_addr_reg;
        clr_resp_next  = clr_resp_reg;
        case (state_reg)
            S_CLEAR: begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1) begin
                    clr_resp_next = 1'b0;
                    state_next    = clr_resp_reg ? S_WB : S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    func_next = s_func;
                    byte_next = s_key_byte;
                    last_next = s_last_byte;
                    idx_next  = ent_idx;
                    val_next  = ent_val;
                    case (s_func)
                        hll_pkg::FUNC_KEY:   state_next = S_FNV;
                        hll_pkg::FUNC_HASH:  state_next = S_RHO;
                        hll_pkg::FUNC_MERGE: state_next = S_RD;
                        hll_pkg::FUNC_READ:  state_next = S_RD;
                        hll_pkg::FUNC_CLEAR: begin
                            clr_addr_next = '0;
                            clr_resp_next = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_FNV: begin
                if (last_reg) begin
                    run_hash_next = hll_pkg::FNV_BASIS;
                    state_next    = S_MIX;
                end else begin
                    run_hash_next = fnv_next;
                    state_next    = S_IDLE;
                end
            end
            S_MIX: begin
                if (fmix_done) begin
                    state_next = S_RHO;
                end
            end
            S_RHO: begin
                if (rho_done) begin
                    idx_next   = rho_idx;
                    val_next   = rho_val;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                state_next = S_WB;
            end
            S_WB: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: load on write-back, drop on transfer
    always_comb begin
        m_valid_next = m_valid_reg;
        kind_next    = kind_reg;
        index_next   = index_reg;
        value_next   = value_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            case (func_reg)
                hll_pkg::FUNC_CLEAR: begin
                    kind_next  = hll_pkg::KIND_CLEAR;
                    index_next = '0;
                    value_next = '0;
                end
                hll_pkg::FUNC_READ: begin
                    kind_next  = hll_pkg::KIND_READ;
                    index_next = idx_ext[hll_pkg::INDEX_W-1:0];
                    value_next = mem_rdata;
                end
                default: begin
                    kind_next  = hll_pkg::KIND_UPDATE;
                    index_next = idx_ext[hll_pkg::INDEX_W-1:0];
                    value_next = merged;
                end
            endcase
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            precision_reg <= hll_pkg::PREC_RESET;
            run_hash_reg  <= hll_pkg::FNV_BASIS;
            clr_addr_reg  <= '0;
            clr_resp_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            precision_reg <= precision_next;
            run_hash_reg  <= run_hash_next;
            clr_addr_reg  <= clr_addr_next;
            clr_resp_reg  <= clr_resp_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        func_reg  <= func_next;
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        idx_reg   <= idx_next;
        val_reg   <= val_next;
        kind_reg  <= kind_next;
        index_reg <= index_next;
        value_reg <= value_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_out_kind  = kind_reg;
    assign m_out_index = index_reg;
    assign m_out_value = value_reg;

    hll_fmix u_fmix (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (fmix_start),
        .hash_in  (fnv_next),
        .done     (fmix_done),
        .hash_out (fmix_hash)
    );

    hll_rho #(
        .IDX_W (IDX_W)
    ) u_rho (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rho_start),
        .hash_in  (rho_hash),
        .prec     (eff_prec),
        .idx_mask (prec_mask),
        .done     (rho_done),
        .idx      (rho_idx),
        .rho      (rho_val)
    );

    hll_mem #(
        .ADDR_W (IDX_W),
        .DATA_W (hll_pkg::VALUE_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (idx_reg),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/hll_mem.sv
// ----------------------------------------------------------------------------
// HyperLogLog sketch register memory
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read data output.
// ----------------------------------------------------------------------------
`default_nettype none

module hll_mem #(
    parameter int ADDR_W = 14,
    parameter int DATA_W = 6
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem_array [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_array[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/hll_fmix.sv
// ----------------------------------------------------------------------------
// HyperLogLog 64-bit finalizer
// Iterative hash mixer: xor-shift, multiply, xor-shift, multiply, xor-shift.
// Each 64x64 (mod 2^64) multiply is formed from the lo*lo, lo*hi and hi*lo
// partial products, taken in turn on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module hll_fmix (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire hll_pkg::hash_t hash_in,
    output logic               done,
    output hll_pkg::hash_t     hash_out
);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic           round_reg, round_next;
    logic [1:0]     step_reg, step_next;
    hll_pkg::hash_t x_reg, x_next;
    hll_pkg::hash_t acc_reg, acc_next;

    hll_pkg::hash_t k_sel;
    logic [31:0]    mul_a;
    logic [31:0]    mul_b;
    logic [63:0]    prod;
    logic [31:0]    acc_hi_sum;
    hll_pkg::hash_t full_prod;

    // Select partial product operands: lo*lo, lo*hi, hi*lo
    always_comb begin
        k_sel = round_reg ? hll_pkg::MIX_K2 : hll_pkg::MIX_K1;
        case (step_reg)
            2'd0: begin
                mul_a = x_reg[31:0];
                mul_b = k_sel[31:0];
            end
            2'd1: begin
                mul_a = x_reg[31:0];
                mul_b = k_sel[63:32];
            end
            2'd2: begin
                mul_a = x_reg[63:32];
                mul_b = k_sel[31:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod       = 64'(mul_a) * 64'(mul_b);
        acc_hi_sum = acc_reg[63:32] + prod[31:0];
        full_prod  = {acc_hi_sum, acc_reg[31:0]};
    end

    // Sequence the two multiply rounds
    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        round_next = round_reg;
        step_next  = step_reg;
        x_next     = x_reg;
        acc_next   = acc_reg;
        if (start) begin
            busy_next  = 1'b1;
            round_next = 1'b0;
            step_next  = 2'd0;
            x_next     = hash_in ^ (hash_in >> hll_pkg::MIX_SHIFT);
        end else if (busy_reg) begin
            case (step_reg)
                2'd0: begin
                    acc_next  = prod;
                    step_next = 2'd1;
                end
                2'd1: begin
                    acc_next  = {acc_hi_sum, acc_reg[31:0]};
                    step_next = 2'd2;
                end
                default: begin
                    x_next    = full_prod ^ (full_prod >> hll_pkg::MIX_SHIFT);
                    step_next = 2'd0;
                    if (round_reg) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end else begin
                        round_next = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= 1'b0;
            step_reg  <= 2'd0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            round_reg <= round_next;
            step_reg  <= step_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        acc_reg <= acc_next;
    end

    assign done     = done_reg;
    assign hash_out = x_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/hll_rho.sv
// ----------------------------------------------------------------------------
// HyperLogLog index and rank unit
// Two-stage pipeline: stage one shifts the top prec hash bits out and finds the
// leading-zero count inside each byte; stage two picks the first non-zero
// byte and forms the rank (leading zeros plus one, or 65-p when empty).
// ----------------------------------------------------------------------------
`default_nettype none

module hll_rho #(
    parameter int IDX_W = 14
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire hll_pkg::hash_t    hash_in,
    input  wire hll_pkg::prec_t    prec,
    input  wire logic [IDX_W-1:0]  idx_mask,
    output logic                   done,
    output logic [IDX_W-1:0]       idx,
    output hll_pkg::value_t        rho
);

    localparam int NBYTES = hll_pkg::HASH_W / 8;

    // Stage one
    logic                 v1_reg;
    logic [NBYTES-1:0]    nz_reg;
    logic [2:0]           lz_reg [NBYTES];
    hll_pkg::prec_t       p1_reg;
    logic [IDX_W-1:0]     idx1_reg;

    // Stage two
    logic                 done_reg;
    logic [IDX_W-1:0]     idx2_reg;
    hll_pkg::value_t      rho_reg;

    hll_pkg::hash_t       w;
    logic [NBYTES-1:0]    nz_next;
    logic [2:0]           lz_next [NBYTES];
    logic                 found;
    logic [5:0]           lzc;
    logic [6:0]           rank;

    // Shift out the top prec hash bits and count leading zeros per byte
    always_comb begin
        w = hash_in << prec;
        for (int b = 0; b < NBYTES; b++) begin
            nz_next[b] = |w[8*b +: 8];
            lz_next[b] = 3'd0;
            found      = 1'b0;
            for (int i = 7; i >= 0; i--) begin
                if (!found && w[8*b + i]) begin
                    lz_next[b] = 3'(7 - i);
                    found      = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        nz_reg   <= nz_next;
        lz_reg   <= lz_next;
        p1_reg   <= prec;
        idx1_reg <= hash_in[IDX_W-1:0] & idx_mask;
    end

    // Pick the most significant non-zero byte
    always_comb begin
        lzc = 6'd0;
        for (int b = 0; b < NBYTES; b++) begin
            if (nz_reg[b]) begin
                lzc = 6'((NBYTES - 1 - b) * 8) + 6'(lz_reg[b]);
            end
        end
        if (nz_reg == '0) begin
            rank = 7'd65 - 7'(p1_reg);
        end else begin
            rank = 7'(lzc) + 7'd1;
        end
    end

    always_ff @(posedge aclk) begin
        idx2_reg <= idx1_reg;
        rho_reg  <= rank[hll_pkg::VALUE_W-1:0];
    end

    // Advance the valid flag through both stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            v1_reg   <= start;
            done_reg <= v1_reg;
        end
    end

    assign done = done_reg;
    assign idx  = idx2_reg;
    assign rho  = rho_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/hll_checker.sv
// ----------------------------------------------------------------------------
// HyperLogLog sketch update - port checker
// Concurrent checks on the top level ports, bound to every instance.
// ----------------------------------------------------------------------------
`default_nettype none

module hll_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_valid,
    input wire logic                        s_ready,
    input wire hll_pkg::func_t              s_func,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire hll_pkg::kind_t              m_out_kind,
    input wire logic [hll_pkg::INDEX_W-1:0] m_out_index,
    input wire hll_pkg::value_t             m_out_value
);

    // A stalled result holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_kind)
                                && $stable(m_out_index) && $stable(m_out_value))
        else $error("stalled result changed");

    // Clearing pass after reset holds off input transfers
    assert property (@(posedge aclk)
        $past(!aresetn) |-> !s_ready && !m_valid)
        else $error("block ready right after reset");

    // A valid operation keeps the block busy for the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_func <= hll_pkg::FUNC_CLEAR) |=> !s_ready)
        else $error("input accepted back to back");

    // Clear done carries zero index and value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_out_kind == hll_pkg::KIND_CLEAR)
            |-> (m_out_index == '0) && (m_out_value == '0))
        else $error("clear result not zero");

    // Register values never exceed the rank ceiling
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_out_value <= hll_pkg::RHO_LIMIT)
        else $error("register value above ceiling");

endmodule

bind hyperloglog_sketch_update hll_checker u_hll_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_func      (s_func),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_kind  (m_out_kind),
    .m_out_index (m_out_index),
    .m_out_value (m_out_value)
);

`default_nettype wire

FILE: tb/hll_update_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HyperLogLog sketch update - result checker
// Watches the configuration, input and result channels of the sketch
// update block. It keeps its own copy of the register file, the running key
// hash and the precision, works out the reply, if any, for every accepted input
// transfer and compares each result transfer, field by field, with the
// oldest reply due.
// ----------------------------------------------------------------------------
module hll_update_checker
    import hll_pkg::*;
#(
    parameter int MAX_PREC = 14
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 s_valid,
    input  wire logic                 s_ready,
    input  wire func_t                s_func,
    input  wire logic [KEY_W-1:0]     s_key_byte,
    input  wire logic                 s_last_byte,
    input  wire hash_t                s_hash_in,
    input  wire logic [INDEX_W-1:0]   s_entry_index,
    input  wire value_t               s_entry_value,
    input  wire logic                 m_valid,
    input  wire logic                 m_ready,
    input  wire kind_t                m_out_kind,
    input  wire logic [INDEX_W-1:0]   m_out_index,
    input  wire value_t               m_out_value,
    output int                        fail_count,
    output int                        replies_due
);

    localparam int    SLOTS       = 1 << MAX_PREC;
    localparam hash_t FNV_PRIME   = 64'h0000_0100_0000_01b3;
    localparam int    MAX_REPORTS = 10;

    typedef struct packed {
        kind_t                kind;
        logic [INDEX_W-1:0]   index;
        value_t               value;
    } sketch_reply_t;

    value_t            sketch_model [SLOTS];
    hash_t             key_hash;
    logic [CFG_W-1:0]  prec_cfg;
    sketch_reply_t     reply_queue [$];

    initial begin
        fail_count  = 0;
        replies_due = 0;
    end

    // Clamp the programmed precision to the supported range
    function automatic int active_prec(input logic [CFG_W-1:0] cfg);
        if (cfg < MIN_PREC) return MIN_PREC;
        if (cfg > MAX_PREC) return MAX_PREC;
        return cfg;
    endfunction

    // 64-bit avalanche mix applied to a closed key hash
    function automatic hash_t finalize(input hash_t h);
        h = h ^ (h >> MIX_SHIFT);
        h = h * MIX_K1;
        h = h ^ (h >> MIX_SHIFT);
        h = h * MIX_K2;
        h = h ^ (h >> MIX_SHIFT);
        return h;
    endfunction

    // Rank: position of the first set bit once the top p bits are shifted out
    function automatic value_t rank_of(input hash_t h, input int p);
        hash_t  w;
        value_t n;
        w = h << p;
        if (w == '0) return value_t'(65 - p);
        n = 1;
        while (!w[HASH_W-1]) begin
            w = w << 1;
            n = n + 1;
        end
        return n;
    endfunction

    // Max-merge the rank of a hash into its register and queue the reply
    task automatic absorb_hash(input hash_t h, input int p);
        logic [INDEX_W-1:0] slot;
        value_t             r;
        slot = h[INDEX_W-1:0] & INDEX_W'((1 << p) - 1);
        r    = rank_of(h, p);
        if (r > sketch_model[slot]) sketch_model[slot] = r;
        reply_queue.push_back({KIND_UPDATE, slot, sketch_model[slot]});
    endtask

    // Advance the sketch copy by one accepted input transfer
    task automatic predict_item(
        input func_t              f,
        input logic [KEY_W-1:0]   kb,
        input logic               lb,
        input hash_t              h,
        input logic [INDEX_W-1:0] ix,
        input value_t             v
    );
        int                 p;
        logic [INDEX_W-1:0] slot;
        value_t             capped;
        p    = active_prec(prec_cfg);
        slot = ix & INDEX_W'((1 << p) - 1);
        case (f)
            FUNC_KEY: begin
                key_hash = (key_hash ^ hash_t'(kb)) * FNV_PRIME;
                if (lb) begin
                    absorb_hash(finalize(key_hash), p);
                    key_hash = FNV_BASIS;
                end
            end
            FUNC_HASH: begin
                absorb_hash(h, p);
            end
            FUNC_MERGE: begin
                capped = (v > RHO_LIMIT) ? RHO_LIMIT : v;
                if (capped > sketch_model[slot]) sketch_model[slot] = capped;
                reply_queue.push_back({KIND_UPDATE, slot, sketch_model[slot]});
            end
            FUNC_READ: begin
                reply_queue.push_back({KIND_READ, slot, sketch_model[slot]});
            end
            FUNC_CLEAR: begin
                foreach (sketch_model[i]) sketch_model[i] = '0;
                reply_queue.push_back({KIND_CLEAR, INDEX_W'(0), value_t'(0)});
            end
            default: begin
                // drop unused operation codes
            end
        endcase
    endtask

    // Compare results first: a result never stems from the input of the same edge
    always @(posedge aclk) begin
        sketch_reply_t got;
        sketch_reply_t want;
        if (!aresetn) begin
            foreach (sketch_model[i]) sketch_model[i] = '0;
            key_hash = FNV_BASIS;
            prec_cfg = PREC_RESET;
            reply_queue.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = {m_out_kind, m_out_index, m_out_value};
                if (reply_queue.size() == 0) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= MAX_REPORTS)
                        $display("hll check: unexpected result kind %0d index %0d value %0d",
                                 got.kind, got.index, got.value);
                end else begin
                    want = reply_queue.pop_front();
                    if (got.kind !== want.kind || got.index !== want.index ||
                        got.value !== want.value) begin
                        fail_count = fail_count + 1;
                        if (fail_count <= MAX_REPORTS)
                            $display({"hll check: mismatch, expected kind %0d index %0d ",
                                      "value %0d, got kind %0d index %0d value %0d"},
                                     want.kind, want.index, want.value,
                                     got.kind, got.index, got.value);
                    end
                end
            end
            if (cfg_valid && cfg_ready) prec_cfg = cfg_data;
            if (s_valid && s_ready)
                predict_item(s_func, s_key_byte, s_last_byte, s_hash_in,
                             s_entry_index, s_entry_value);
        end
        replies_due = reply_queue.size();
    end

endmodule

FILE: tb/tb_hyperloglog_sketch_update.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HyperLogLog sketch update - testbench top
// Drives key bytes, direct hashes, entry merges, reads, clears and unused
// operation codes into the sketch update block across several precision
// settings and handshake idling patterns, including a long result
// back-pressure stretch. A separate checker predicts and compares every
// result; this module makes the stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_hyperloglog_sketch_update;
    import hll_pkg::*;

    localparam int    SKETCH_PREC_MAX = 14;
    localparam int    NUM_PHASES      = 8;
    localparam int    PHASE_ITEMS     = 240;
    localparam int    HOLD_CYCLES     = 400;
    localparam int    SETTLE_CYCLES   = 40;
    localparam int    CYCLE_LIMIT     = 1_500_000;
    localparam func_t FUNC_UNUSED_LO  = 3'd5;
    localparam func_t FUNC_UNUSED_HI  = 3'd7;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    func_t                s_func;
    logic [KEY_W-1:0]     s_key_byte;
    logic                 s_last_byte;
    hash_t                s_hash_in;
    logic [INDEX_W-1:0]   s_entry_index;
    value_t               s_entry_value;
    logic                 m_valid;
    logic                 m_ready;
    kind_t                m_out_kind;
    logic [INDEX_W-1:0]   m_out_index;
    value_t               m_out_value;

    int                   fail_count;
    int                   replies_due;
    int                   cycle_count;
    int                   items_sent;
    int                   send_idle_pct;
    int                   stall_pct;
    bit                   hold_req;

    hyperloglog_sketch_update #(
        .MAX_PREC (SKETCH_PREC_MAX)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_key_byte    (s_key_byte),
        .s_last_byte   (s_last_byte),
        .s_hash_in     (s_hash_in),
        .s_entry_index (s_entry_index),
        .s_entry_value (s_entry_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_kind    (m_out_kind),
        .m_out_index   (m_out_index),
        .m_out_value   (m_out_value)
    );

    hll_update_checker #(
        .MAX_PREC (SKETCH_PREC_MAX)
    ) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_key_byte    (s_key_byte),
        .s_last_byte   (s_last_byte),
        .s_hash_in     (s_hash_in),
        .s_entry_index (s_entry_index),
        .s_entry_value (s_entry_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_kind    (m_out_kind),
        .m_out_index   (m_out_index),
        .m_out_value   (m_out_value),
        .fail_count    (fail_count),
        .replies_due   (replies_due)
    );

    // Clock
    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Abort a hung run
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one input transfer after a random idle stretch, hold until taken
    task automatic offer(
        input func_t              f,
        input logic [KEY_W-1:0]   kb,
        input logic               lb,
        input hash_t              h,
        input logic [INDEX_W-1:0] ix,
        input value_t             v
    );
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= f;
        s_key_byte    <= kb;
        s_last_byte   <= lb;
        s_hash_in     <= h;
        s_entry_index <= ix;
        s_entry_value <= v;
        do @(posedge aclk); while (!s_ready);
        if (f <= FUNC_CLEAR) items_sent = items_sent + 1;
    endtask

    function automatic hash_t random_hash();
        hash_t h;
        h = {$urandom, $urandom};
        // thin out the high bits now and then to reach the long ranks
        if ($urandom_range(3) == 0) h = h >> $urandom_range(63);
        return h;
    endfunction

    // Operation helpers; fields the operation ignores carry random data
    task automatic put_key_byte(input logic [KEY_W-1:0] kb, input logic lb);
        offer(FUNC_KEY, kb, lb, random_hash(), INDEX_W'($urandom), VALUE_W'($urandom));
    endtask

    task automatic put_hash(input hash_t h);
        offer(FUNC_HASH, KEY_W'($urandom), 1'($urandom), h, INDEX_W'($urandom),
              VALUE_W'($urandom));
    endtask

    task automatic put_merge(input logic [INDEX_W-1:0] ix, input value_t v);
        offer(FUNC_MERGE, KEY_W'($urandom), 1'($urandom), random_hash(), ix, v);
    endtask

    task automatic put_read(input logic [INDEX_W-1:0] ix);
        offer(FUNC_READ, KEY_W'($urandom), 1'($urandom), random_hash(), ix,
              VALUE_W'($urandom));
    endtask

    task automatic put_clear();
        offer(FUNC_CLEAR, KEY_W'($urandom), 1'($urandom), random_hash(),
              INDEX_W'($urandom), VALUE_W'($urandom));
    endtask

    task automatic put_unused(input func_t f);
        offer(f, KEY_W'($urandom), 1'($urandom), random_hash(), INDEX_W'($urandom),
              VALUE_W'($urandom));
    endtask

    // Stream a whole key, last byte flagged
    task automatic put_key(input int len);
        for (int i = 1; i <= len; i++) put_key_byte(KEY_W'($urandom), i == len);
    endtask

    // Drop valid, wait for every reply, then let the pipeline drain
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (replies_due != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_precision(input logic [CFG_W-1:0] p);
        cfg_valid <= 1'b1;
        cfg_data  <= p;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Stimulus
    initial begin
        logic [CFG_W-1:0] prec_plan [NUM_PHASES];
        int               phase_start;
        int               pick;
        bit               cleared;
        bit               held;

        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_func        = FUNC_KEY;
        s_key_byte    = '0;
        s_last_byte   = 1'b0;
        s_hash_in     = '0;
        s_entry_index = '0;
        s_entry_value = '0;
        items_sent    = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = 1'b0;
        held          = 1'b0;

        prec_plan = '{4'd4, 4'd15, 4'd0, 4'd14, 4'd9, CFG_W'($urandom), 4'd6, 4'd12};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed checks at the reset precision
        put_read('0);
        put_read('1);
        put_merge('1, 6'd63);
        put_merge('0, 6'd62);
        put_merge(14'h1234, RHO_LIMIT);
        put_merge(14'h2aaa, 6'd0);
        put_read('1);
        put_hash('0);
        put_hash('1);
        put_hash(64'h0000_0000_0000_1555);
        put_hash(64'h0000_0004_0000_0005);
        put_key_byte(8'h00, 1'b1);
        put_key_byte(8'hff, 1'b0);
        put_key_byte(8'h5a, 1'b0);
        put_key_byte(8'ha5, 1'b1);
        // a partial key must survive unrelated operations
        put_key_byte(8'h3c, 1'b0);
        put_read(14'h1234);
        put_hash(random_hash());
        put_key_byte(8'hc3, 1'b1);
        put_unused(FUNC_UNUSED_LO);
        put_unused(FUNC_UNUSED_HI);
        put_clear();
        put_read('0);
        put_merge('0, 6'd1);

        // Random phases, each with its own precision and idling pattern
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            write_precision(prec_plan[ph]);
            case (ph % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 46;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 46;
                end
                default: begin
                    send_idle_pct = 32;
                    stall_pct     = 32;
                end
            endcase
            phase_start = items_sent;
            cleared     = 1'b0;
            while (items_sent < phase_start + PHASE_ITEMS) begin
                // back up the result side once while the sender keeps going
                if (!held && items_sent >= phase_start + 80) begin
                    hold_req = 1'b1;
                    held     = 1'b1;
                end
                if (!cleared && items_sent >= phase_start + PHASE_ITEMS / 2) begin
                    put_clear();
                    cleared = 1'b1;
                end
                pick = $urandom_range(99);
                if (pick < 40)
                    put_key($urandom_range(1, 6));
                else if (pick < 48)
                    put_key_byte(KEY_W'($urandom), 1'($urandom));
                else if (pick < 68)
                    put_hash(random_hash());
                else if (pick < 80)
                    put_merge(INDEX_W'($urandom), VALUE_W'($urandom));
                else if (pick < 94)
                    put_read(INDEX_W'($urandom));
                else
                    put_unused(func_t'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI)));
            end
        end

        settle();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/hll_pkg.sv
hw/rtl/hll_mem.sv
hw/rtl/hll_fmix.sv
hw/rtl/hll_rho.sv
hw/rtl/hyperloglog_sketch_update.sv
hw/rtl/hll_checker.sv
tb/hll_update_checker.sv
tb/tb_hyperloglog_sketch_update.sv
